// ----- src/rwlm_pkg.sv -----
// rwlm_pkg: shared types and codes of the reader-writer lock manager
// holds request/response payload structs and the controller/datapath link
// no dependencies
`timescale 1ns / 1ps

package rwlm_pkg;

  localparam int unsigned TaskW = 8;
  localparam int unsigned HoldW = 9;

  // request commands
  typedef enum logic [1:0] {
    CMD_READ    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  // response status codes
  localparam logic [2:0] ST_GRANTED  = 3'd0;
  localparam logic [2:0] ST_QUEUED   = 3'd1;
  localparam logic [2:0] ST_WOKEN    = 3'd2;
  localparam logic [2:0] ST_NONE     = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_NOHOLDER = 3'd5;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [TaskW-1:0] task_id;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [TaskW-1:0] granted_task;
    logic             grant_is_writer;
    logic [HoldW-1:0] readers_holding;
    logic             writer_holding;
    logic             last;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic latch;    // capture the request
    logic execute;  // apply the decision, load a single result
    logic emit;     // load one woken task and pop its queue
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic no_op;     // unused command
    logic wake;      // hand-off to a queue
    logic more;      // further readers left after this pop
    logic out_free;  // response register can be loaded
  } ctl_sts_t;

endpackage

// ----- src/rwlm_ram.sv -----
// rwlm_ram: generic single write, single read memory with registered read
// no dependencies
`timescale 1ns / 1ps

module rwlm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/rwlm_ctrl.sv -----
// rwlm_ctrl: sequencer of the lock manager
// depends on rwlm_pkg
`timescale 1ns / 1ps

module rwlm_ctrl
  import rwlm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  ctl_sts_t sts_i,
  output ctl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_READ,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o.latch   = 1'b0;
    cmd_o.execute = 1'b0;
    cmd_o.emit    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.no_op) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.execute = 1'b1;
          state_d       = sts_i.wake ? S_READ : S_IDLE;
        end
      end
      // queue head address is on the ram this cycle
      S_READ: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.more ? S_READ : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);

endmodule

// ----- src/rwlm_dpath.sv -----
// rwlm_dpath: lock state, wait queues and response register
// depends on rwlm_pkg and rwlm_ram
`timescale 1ns / 1ps

module rwlm_dpath
  import rwlm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned TASK_ID_WIDTH = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  input  req_t     req_i,
  input  ctl_cmd_t cmd_i,
  output ctl_sts_t sts_o,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  output rsp_t     rsp_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IdW  = TASK_ID_WIDTH;

  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  // lock state
  logic             writer_first_q;
  logic             wh_q, wh_n;
  logic [HoldW-1:0] rh_q, rh_n;
  logic [PtrW-1:0]  rhead_q, whead_q;
  logic [CntW-1:0]  rcnt_q, wcnt_q;
  logic             wake_wr_q;

  // captured request
  cmd_e             req_cmd_q;
  logic [IdW-1:0]   req_id_q;

  // response register
  logic             out_valid_q;
  rsp_t             out_q;

  // id width conversion
  logic [IdW+TaskW-1:0] id_in_ext, id_out_ext, id_rd_ext, id_wr_ext;
  logic [IdW-1:0]       rdata_r, rdata_w;

  assign id_in_ext  = {{IdW{1'b0}}, req_i.task_id};
  assign id_out_ext = {{TaskW{1'b0}}, req_id_q};
  assign id_rd_ext  = {{TaskW{1'b0}}, rdata_r};
  assign id_wr_ext  = {{TaskW{1'b0}}, rdata_w};

  // decision
  logic       rfull, wfull, has_holder, pick_wr;
  logic       push_r, push_w, wake_wr, wake_rd, single, no_op;
  logic [2:0] st;
  logic       wr_flag;
  logic [HoldW-1:0] after_r;

  assign rfull      = (rcnt_q == CntFull);
  assign wfull      = (wcnt_q == CntFull);
  assign has_holder = wh_q || (rh_q != '0);
  assign after_r    = wh_q ? rh_q : rh_q - HoldW'(1);
  assign pick_wr    = (writer_first_q && (wcnt_q != '0)) || (rcnt_q == '0);

  always_comb begin
    wh_n    = wh_q;
    rh_n    = rh_q;
    push_r  = 1'b0;
    push_w  = 1'b0;
    wake_wr = 1'b0;
    wake_rd = 1'b0;
    single  = 1'b1;
    no_op   = 1'b0;
    st      = ST_NONE;
    wr_flag = 1'b0;
    case (req_cmd_q)
      CMD_READ: begin
        // top bit of the holder count marks saturation
        if (!wh_q && !rh_q[HoldW-1] && (!writer_first_q || (wcnt_q == '0))) begin
          rh_n = rh_q + HoldW'(1);
          st   = ST_GRANTED;
        end else if (!rfull) begin
          push_r = 1'b1;
          st     = ST_QUEUED;
        end else begin
          st = ST_FULL;
        end
      end
      CMD_WRITE: begin
        wr_flag = 1'b1;
        if (!wh_q && (rh_q == '0)) begin
          wh_n = 1'b1;
          st   = ST_GRANTED;
        end else if (!wfull) begin
          push_w = 1'b1;
          st     = ST_QUEUED;
        end else begin
          st = ST_FULL;
        end
      end
      CMD_RELEASE: begin
        if (!has_holder) begin
          st = ST_NOHOLDER;
        end else begin
          wh_n = 1'b0;
          rh_n = after_r;
          if (after_r != '0) begin
            st = ST_NONE;
          end else if (pick_wr) begin
            if (wcnt_q != '0) begin
              wh_n    = 1'b1;
              wake_wr = 1'b1;
              single  = 1'b0;
            end else begin
              st = ST_NONE;
            end
          end else begin
            // every waiting reader becomes a holder
            rh_n    = HoldW'(rcnt_q);
            wake_rd = 1'b1;
            single  = 1'b0;
          end
        end
      end
      default: begin
        single = 1'b0;
        no_op  = 1'b1;
      end
    endcase
  end

  // queue addressing
  logic [CntW:0]   rsum, wsum;
  logic [PtrW-1:0] rtail, wtail;
  logic [PtrW-1:0] rhead_inc, whead_inc;
  logic            pop_r, pop_w;

  assign rsum  = {1'b0, CntW'(rhead_q)} + {1'b0, rcnt_q};
  assign wsum  = {1'b0, CntW'(whead_q)} + {1'b0, wcnt_q};
  assign rtail = (rsum >= (CntW+1)'(QUEUE_DEPTH)) ?
                 PtrW'(rsum - (CntW+1)'(QUEUE_DEPTH)) : PtrW'(rsum);
  assign wtail = (wsum >= (CntW+1)'(QUEUE_DEPTH)) ?
                 PtrW'(wsum - (CntW+1)'(QUEUE_DEPTH)) : PtrW'(wsum);
  assign rhead_inc = (rhead_q == PtrLast) ? '0 : rhead_q + PtrW'(1);
  assign whead_inc = (whead_q == PtrLast) ? '0 : whead_q + PtrW'(1);
  assign pop_r     = cmd_i.emit && !wake_wr_q;
  assign pop_w     = cmd_i.emit && wake_wr_q;

  rwlm_ram #(
    .WIDTH (IdW),
    .DEPTH (QUEUE_DEPTH)
  ) u_rd_queue (
    .clk_i   (clk_i),
    .we_i    (cmd_i.execute && push_r),
    .waddr_i (rtail),
    .wdata_i (req_id_q),
    .raddr_i (rhead_q),
    .rdata_o (rdata_r)
  );

  rwlm_ram #(
    .WIDTH (IdW),
    .DEPTH (QUEUE_DEPTH)
  ) u_wr_queue (
    .clk_i   (clk_i),
    .we_i    (cmd_i.execute && push_w),
    .waddr_i (wtail),
    .wdata_i (req_id_q),
    .raddr_i (whead_q),
    .rdata_o (rdata_w)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      writer_first_q <= 1'b0;
      wh_q           <= 1'b0;
      rh_q           <= '0;
      rhead_q        <= '0;
      whead_q        <= '0;
      rcnt_q         <= '0;
      wcnt_q         <= '0;
      wake_wr_q      <= 1'b0;
      req_cmd_q      <= CMD_UNUSED;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        writer_first_q <= cfg_wdata_i;
      end
      if (cmd_i.latch) begin
        req_cmd_q <= cmd_e'(req_i.cmd);
      end
      if (cmd_i.execute) begin
        wh_q      <= wh_n;
        rh_q      <= rh_n;
        wake_wr_q <= wake_wr;
        if (push_r) begin
          rcnt_q <= rcnt_q + CntW'(1);
        end
        if (push_w) begin
          wcnt_q <= wcnt_q + CntW'(1);
        end
      end
      if (pop_r) begin
        rhead_q <= rhead_inc;
        rcnt_q  <= rcnt_q - CntW'(1);
      end
      if (pop_w) begin
        whead_q <= whead_inc;
        wcnt_q  <= wcnt_q - CntW'(1);
      end
      if ((cmd_i.execute && single) || cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_id_q <= id_in_ext[IdW-1:0];
    end
    if (cmd_i.execute && single) begin
      out_q.status          <= st;
      out_q.granted_task    <= id_out_ext[TaskW-1:0];
      out_q.grant_is_writer <= wr_flag && (st != ST_NONE) && (st != ST_NOHOLDER);
      out_q.readers_holding <= rh_n;
      out_q.writer_holding  <= wh_n;
      out_q.last            <= 1'b1;
    end else if (cmd_i.emit) begin
      out_q.status          <= ST_WOKEN;
      out_q.granted_task    <= wake_wr_q ? id_wr_ext[TaskW-1:0] : id_rd_ext[TaskW-1:0];
      out_q.grant_is_writer <= wake_wr_q;
      out_q.readers_holding <= rh_q;
      out_q.writer_holding  <= wh_q;
      out_q.last            <= wake_wr_q || (rcnt_q == CntOne);
    end
  end

  assign sts_o.no_op    = no_op;
  assign sts_o.wake     = wake_wr || wake_rd;
  assign sts_o.more     = !wake_wr_q && (rcnt_q > CntOne);
  assign sts_o.out_free = !out_valid_q || rsp_ready_i;

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

endmodule

// ----- src/reader_writer_lock_manager_core.sv -----
// reader_writer_lock_manager_core: top level of the hardware reader-writer lock
// depends on rwlm_pkg, rwlm_ctrl, rwlm_dpath (and rwlm_ram below it)
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------------
//   req     | in        | req_valid_i / req_ready_o | req_i  (cmd, task_id)
//   rsp     | out       | rsp_valid_o / rsp_ready_i | rsp_o  (status .. last)
//   cfg     | in        | cfg_we_i, no wait         | cfg_wdata_i (writer_first)
//
// a request is taken only while the sequencer is idle; after a grant, queue, refuse
// or plain release the sequencer goes from decide back to idle for the next request
// a hand-off passes through the queue read and emit states for each woken task, as
// the queue ram read is registered; all waiting readers, up to QUEUE_DEPTH, may be woken
// a stalled response holds the sequencer until the result register frees up
// reset clears holders and both queue counts; queue ram contents are not cleared
`timescale 1ns / 1ps

module reader_writer_lock_manager_core
  import rwlm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned TASK_ID_WIDTH = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  // configuration write, writer_first bit
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  // request channel
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  // response channel
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  // command and status link between sequencer and datapath
  ctl_cmd_t ctl_cmd;
  ctl_sts_t ctl_sts;

  // sequencer: idle, decide, queue read, emit woken task
  rwlm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .sts_i       (ctl_sts),
    .cmd_o       (ctl_cmd)
  );

  // holder counts, the two wait queues and the response register
  rwlm_dpath #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .TASK_ID_WIDTH (TASK_ID_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (ctl_cmd),
    .sts_o       (ctl_sts),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

endmodule
